/* hdl/sparse_polynomial_add_macros.svh */
// Assertion helpers, compiled out for synthesis.
`ifndef SPARSE_POLYNOMIAL_ADD_MACROS_SVH
`define SPARSE_POLYNOMIAL_ADD_MACROS_SVH

`ifndef SYNTHESIS
`define SPA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("spa assertion failed");
`define SPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("spa assertion failed");
`else
`define SPA_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define SPA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* hdl/spa_pkg.sv */
package spa_pkg;

	localparam int TERMS_DEFAULT = 16;

	localparam int COEFF_W = 16;
	localparam int EXPON_W = 8;
	localparam int SUM_W   = 17;
	localparam int OPC_W   = 2;

	localparam logic [OPC_W-1:0] OP_LOAD_A = 2'd0;
	localparam logic [OPC_W-1:0] OP_LOAD_B = 2'd1;
	localparam logic [OPC_W-1:0] OP_SUM    = 2'd2;

endpackage

/* hdl/spa_ram.sv */
module spa_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 16
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* hdl/sparse_polynomial_add.sv */
// Sparse polynomial adder. Load beats (opcode 0 for list A, 1 for list B) append one
// (coefficient, exponent) term; loads into a full list of TERMS terms are dropped. A sum
// beat (opcode 2) merges the lists by exponent, highest first, adds coefficients of equal
// exponents and drops zero sums, then emits the terms with first/last marks, or one beat
// with empty_res, first and last set if nothing is left. Opcode 3 is ignored. A sum runs
// merge steps (a step takes one term off a list, or one off each when exponents match, so
// at most a_count + b_count steps), then sees both lists exhausted and flushes the last
// term; output stalls can hold it up. Each step reads the list RAMs through their single
// registered read port and then compares. The input is not ready while a sum is in
// progress; both lists are empty afterwards.
`include "sparse_polynomial_add_macros.svh"

module sparse_polynomial_add #(
	parameter int TERMS = spa_pkg::TERMS_DEFAULT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [spa_pkg::OPC_W-1:0]        opcode,
	input  logic signed [spa_pkg::COEFF_W-1:0] term_coeff,
	input  logic [spa_pkg::EXPON_W-1:0]      term_expon,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [spa_pkg::SUM_W-1:0] sum_coeff,
	output logic [spa_pkg::EXPON_W-1:0]      sum_expon,
	output logic                             first,
	output logic                             last,
	output logic                             empty_res
);

	localparam int CW = $clog2(TERMS + 1);
	localparam int AW = (TERMS > 1) ? $clog2(TERMS) : 1;
	localparam int DW = spa_pkg::COEFF_W + spa_pkg::EXPON_W;
	localparam int EW = spa_pkg::EXPON_W;
	localparam int KW = spa_pkg::COEFF_W;
	localparam int SW = spa_pkg::SUM_W;

	typedef enum logic [1:0] {ST_IDLE, ST_FETCH, ST_CMP, ST_FLUSH} state_t;

	state_t state_q;
	logic [CW-1:0] a_cnt_q, b_cnt_q, ia_q, ib_q;
	logic          hold_v_q, hold_first_q;
	logic signed [SW-1:0] hold_coeff_q;
	logic [EW-1:0] hold_expon_q;
	logic          out_valid_q, first_q, last_q, empty_q;
	logic signed [SW-1:0] out_coeff_q;
	logic [EW-1:0] out_expon_q;

	logic          in_fire, we_a, we_b;
	logic [DW-1:0] wdata, rd_a, rd_b;
	logic signed [KW-1:0] a_c, b_c;
	logic [EW-1:0] a_e, b_e;
	logic signed [SW-1:0] a_c17, b_c17, pair_sum;
	logic          a_has, b_has, done, pick_v, adv_a, adv_b, stall, out_free;
	logic signed [SW-1:0] pick_coeff;
	logic [EW-1:0] pick_expon;
	logic          flush_go, sum_start, out_load;

	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign wdata    = {term_coeff, term_expon};
	assign we_a     = in_fire && (opcode == spa_pkg::OP_LOAD_A) && (a_cnt_q < CW'(TERMS));
	assign we_b     = in_fire && (opcode == spa_pkg::OP_LOAD_B) && (b_cnt_q < CW'(TERMS));

	spa_ram #(.WIDTH(DW), .DEPTH(TERMS)) u_ram_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (a_cnt_q[AW-1:0]),
		.wdata (wdata),
		.raddr (ia_q[AW-1:0]),
		.rdata (rd_a)
	);

	spa_ram #(.WIDTH(DW), .DEPTH(TERMS)) u_ram_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (b_cnt_q[AW-1:0]),
		.wdata (wdata),
		.raddr (ib_q[AW-1:0]),
		.rdata (rd_b)
	);

	assign a_c      = rd_a[DW-1:EW];
	assign a_e      = rd_a[EW-1:0];
	assign b_c      = rd_b[DW-1:EW];
	assign b_e      = rd_b[EW-1:0];
	assign a_c17    = {a_c[KW-1], a_c};
	assign b_c17    = {b_c[KW-1], b_c};
	assign pair_sum = a_c17 + b_c17;
	assign a_has    = ia_q < a_cnt_q;
	assign b_has    = ib_q < b_cnt_q;
	assign done     = !a_has && !b_has;

	always_comb begin
		pick_v     = 1'b0;
		pick_coeff = a_c17;
		pick_expon = a_e;
		adv_a      = 1'b0;
		adv_b      = 1'b0;
		priority if (a_has && b_has) begin
			priority if (a_e > b_e) begin
				pick_v = 1'b1;
				adv_a  = 1'b1;
			end else if (a_e < b_e) begin
				pick_v     = 1'b1;
				pick_coeff = b_c17;
				pick_expon = b_e;
				adv_b      = 1'b1;
			end else begin
				pick_v     = (pair_sum != '0);
				pick_coeff = pair_sum;
				adv_a      = 1'b1;
				adv_b      = 1'b1;
			end
		end else if (a_has) begin
			pick_v = 1'b1;
			adv_a  = 1'b1;
		end else if (b_has) begin
			pick_v     = 1'b1;
			pick_coeff = b_c17;
			pick_expon = b_e;
			adv_b      = 1'b1;
		end else begin
			pick_v = 1'b0;
		end
	end

	assign out_free  = !out_valid_q || out_ready;
	assign stall     = pick_v && hold_v_q && !out_free;
	assign flush_go  = (state_q == ST_FLUSH) && out_free;
	assign sum_start = in_fire && (opcode == spa_pkg::OP_SUM);
	assign out_load  = flush_go ||
		((state_q == ST_CMP) && !done && !stall && pick_v && hold_v_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			a_cnt_q      <= '0;
			b_cnt_q      <= '0;
			ia_q         <= '0;
			ib_q         <= '0;
			hold_v_q     <= 1'b0;
			hold_first_q <= 1'b0;
			hold_coeff_q <= '0;
			hold_expon_q <= '0;
			out_valid_q  <= 1'b0;
			out_coeff_q  <= '0;
			out_expon_q  <= '0;
			first_q      <= 1'b0;
			last_q       <= 1'b0;
			empty_q      <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						unique case (opcode)
							spa_pkg::OP_LOAD_A: begin
								if (we_a) a_cnt_q <= a_cnt_q + CW'(1);
							end
							spa_pkg::OP_LOAD_B: begin
								if (we_b) b_cnt_q <= b_cnt_q + CW'(1);
							end
							spa_pkg::OP_SUM: begin
								ia_q     <= '0;
								ib_q     <= '0;
								hold_v_q <= 1'b0;
								state_q  <= ST_FETCH;
							end
							default: ;
						endcase
					end
				end
				ST_FETCH: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (done) begin
						state_q <= ST_FLUSH;
					end else if (!stall) begin
						ia_q <= ia_q + CW'(adv_a);
						ib_q <= ib_q + CW'(adv_b);
						if (pick_v) begin
							if (hold_v_q) begin
								out_coeff_q <= hold_coeff_q;
								out_expon_q <= hold_expon_q;
								first_q     <= hold_first_q;
								last_q      <= 1'b0;
								empty_q     <= 1'b0;
							end
							hold_coeff_q <= pick_coeff;
							hold_expon_q <= pick_expon;
							hold_first_q <= !hold_v_q;
							hold_v_q     <= 1'b1;
						end
						state_q <= ST_FETCH;
					end
				end
				ST_FLUSH: begin
					if (out_free) begin
						last_q <= 1'b1;
						if (hold_v_q) begin
							out_coeff_q <= hold_coeff_q;
							out_expon_q <= hold_expon_q;
							first_q     <= hold_first_q;
							empty_q     <= 1'b0;
						end else begin
							out_coeff_q <= '0;
							out_expon_q <= '0;
							first_q     <= 1'b1;
							empty_q     <= 1'b1;
						end
						a_cnt_q  <= '0;
						b_cnt_q  <= '0;
						hold_v_q <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign sum_coeff = out_coeff_q;
	assign sum_expon = out_expon_q;
	assign first     = first_q;
	assign last      = last_q;
	assign empty_res = empty_q;

	`SPA_ASSERT_SAME(a_cnt_bound, clk, arst_n, 1'b1, (a_cnt_q <= CW'(TERMS)) && (b_cnt_q <= CW'(TERMS)))
	`SPA_ASSERT_NEXT(sum_busy, clk, arst_n, sum_start, !in_ready && hold_v_q == 1'b0)
	`SPA_ASSERT_NEXT(flush_last, clk, arst_n, flush_go, out_valid && last && a_cnt_q == '0)
	`SPA_ASSERT_SAME(empty_form, clk, arst_n, out_valid && empty_res, first && last && sum_coeff == '0 && sum_expon == '0)

endmodule
